FILE: rtl/int_and_float_divider_assert.svh
// assertion macros used by the divider checker
`ifndef INT_AND_FLOAT_DIVIDER_ASSERT_SVH
`define INT_AND_FLOAT_DIVIDER_ASSERT_SVH

// clocked implication, disabled while reset is held
`define IFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// clocked implication checked in the following cycle
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ifdiv_pkg.sv
package ifdiv_pkg;

    // fixed field widths
    localparam int MANT_W     = 64;
    localparam int EXP_IN_W   = 16;
    // difference of two exponents plus one step of adjust
    localparam int EXP_CALC_W = EXP_IN_W + 2;
    localparam int CNT_W      = $clog2(MANT_W);
    localparam int EXP_WIDTH_DEF = 16;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_NORM = 2'd2,
        ST_OVF  = 2'd3
    } t_status;

    // request kinds
    typedef enum logic {
        REQ_INT   = 1'b0,
        REQ_FLOAT = 1'b1
    } t_req;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_ROUND,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic round;
        logic finish;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic special;
    } t_dp_stat;

endpackage

FILE: rtl/int_and_float_divider.sv
// Integer and floating-point divider. Raise start for one cycle while busy
// is low to hand over an item; the result appears on the o_q_* and o_status
// ports for exactly one cycle with o_done high, and must be taken then, as
// the block cannot be stalled. A regular division makes one restoring step
// per cycle through a single 65-bit subtractor for all 64 quotient bits, then
// forms the round bit in S_ROUND and the result in S_FINISH. Divide by zero,
// an unnormalized mantissa or a zero floating dividend skip the steps and go
// straight to S_FINISH. A new item can be started in the cycle o_done is high.
module int_and_float_divider
    import ifdiv_pkg::*;
#(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [MANT_W-1:0]          i_a_value,
    input  logic                       i_a_signed,
    input  logic                       i_a_negative,
    input  logic                       i_a_zero,
    input  logic signed [EXP_IN_W-1:0] i_a_exponent,
    input  logic [MANT_W-1:0]          i_b_value,
    input  logic                       i_b_signed,
    input  logic                       i_b_negative,
    input  logic                       i_b_zero,
    input  logic signed [EXP_IN_W-1:0] i_b_exponent,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [MANT_W-1:0]          o_q_value,
    output logic signed [EXP_IN_W-1:0] o_q_exponent,
    output logic                       o_q_signed,
    output logic                       o_q_negative,
    output logic                       o_q_zero
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    ifdiv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // operand registers, divider step and result forming
    ifdiv_dp #(
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_a_value    (i_a_value),
        .i_a_signed   (i_a_signed),
        .i_a_negative (i_a_negative),
        .i_a_zero     (i_a_zero),
        .i_a_exponent (i_a_exponent),
        .i_b_value    (i_b_value),
        .i_b_signed   (i_b_signed),
        .i_b_negative (i_b_negative),
        .i_b_zero     (i_b_zero),
        .i_b_exponent (i_b_exponent),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_q_value    (o_q_value),
        .o_q_exponent (o_q_exponent),
        .o_q_signed   (o_q_signed),
        .o_q_negative (o_q_negative),
        .o_q_zero     (o_q_zero)
    );

endmodule

FILE: rtl/ifdiv_ctrl.sv
module ifdiv_ctrl
    import ifdiv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_count = '0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_stat.special) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_count    = r_count + 1'b1;
                    if (r_count == CNT_W'(MANT_W - 1)) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/ifdiv_dp.sv
module ifdiv_dp
    import ifdiv_pkg::*;
#(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_req_type,
    input  logic [MANT_W-1:0]          i_a_value,
    input  logic                       i_a_signed,
    input  logic                       i_a_negative,
    input  logic                       i_a_zero,
    input  logic signed [EXP_IN_W-1:0] i_a_exponent,
    input  logic [MANT_W-1:0]          i_b_value,
    input  logic                       i_b_signed,
    input  logic                       i_b_negative,
    input  logic                       i_b_zero,
    input  logic signed [EXP_IN_W-1:0] i_b_exponent,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [MANT_W-1:0]          o_q_value,
    output logic signed [EXP_IN_W-1:0] o_q_exponent,
    output logic                       o_q_signed,
    output logic                       o_q_negative,
    output logic                       o_q_zero
);

    // range check width covers both the working exponent and the limits
    localparam int CmpW = (EXP_WIDTH + 1 > EXP_CALC_W) ? EXP_WIDTH + 1 : EXP_CALC_W;
    localparam logic signed [CmpW-1:0] ExpMax =
        CmpW'((64'sd1 <<< (EXP_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CmpW-1:0] ExpMin = -ExpMax - CmpW'(1);

    // working registers
    logic                          r_float;
    logic                          r_sg;
    logic                          r_qneg;
    logic                          r_neg;
    logic                          r_spec;
    t_status                       r_spec_status;
    logic                          r_spec_zero;
    logic [MANT_W:0]               r_rem;
    logic [MANT_W-1:0]             r_q;
    logic [MANT_W-1:0]             r_b;
    logic signed [EXP_CALC_W-1:0]  r_exp;
    logic                          r_round;

    // operand preparation on accept
    logic                          ld_sg;
    logic [MANT_W-1:0]             ld_ma, ld_mb;
    logic                          ld_alt;
    logic                          ld_spec;
    t_status                       ld_spec_status;
    logic                          ld_spec_zero;
    logic signed [EXP_CALC_W-1:0]  ld_exp;

    always_comb begin
        ld_sg  = i_a_signed | i_b_signed;
        ld_ma  = (ld_sg && i_a_value[MANT_W-1]) ? (~i_a_value + 1'b1) : i_a_value;
        ld_mb  = (ld_sg && i_b_value[MANT_W-1]) ? (~i_b_value + 1'b1) : i_b_value;
        ld_alt = (i_a_value < i_b_value);
        ld_exp = EXP_CALC_W'(i_a_exponent) - EXP_CALC_W'(i_b_exponent)
                 - EXP_CALC_W'(ld_alt);
        ld_spec        = 1'b0;
        ld_spec_status = ST_OK;
        ld_spec_zero   = 1'b0;
        if (i_req_type == REQ_INT) begin
            if (i_b_value == '0) begin
                ld_spec        = 1'b1;
                ld_spec_status = ST_DIV0;
            end
        end else begin
            priority if (i_b_zero) begin
                ld_spec        = 1'b1;
                ld_spec_status = ST_DIV0;
            end else if (!i_b_value[MANT_W-1]) begin
                ld_spec        = 1'b1;
                ld_spec_status = ST_NORM;
            end else if (i_a_zero) begin
                ld_spec      = 1'b1;
                ld_spec_zero = 1'b1;
            end else if (!i_a_value[MANT_W-1]) begin
                ld_spec        = 1'b1;
                ld_spec_status = ST_NORM;
            end else begin
                // regular division
                ld_spec = 1'b0;
            end
        end
    end

    // one restoring step: compare, subtract, shift
    logic [MANT_W:0] st_part, st_diff, st_new;
    logic            st_ge;

    always_comb begin
        st_part = r_float ? r_rem : {r_rem[MANT_W-1:0], r_q[MANT_W-1]};
        st_ge   = (st_part >= {1'b0, r_b});
        st_diff = st_part - {1'b0, r_b};
        st_new  = st_ge ? st_diff : st_part;
    end

    // final rounding and exponent range
    logic [MANT_W:0]              fn_inc;
    logic [MANT_W-1:0]            fn_fq;
    logic signed [EXP_CALC_W-1:0] fn_exp;
    logic signed [CmpW-1:0]       fn_exp_w;
    logic                         fn_ovf;

    always_comb begin
        fn_inc   = {1'b0, r_q} + (MANT_W+1)'(r_round);
        fn_fq    = fn_inc[MANT_W] ? {1'b1, {(MANT_W-1){1'b0}}} : fn_inc[MANT_W-1:0];
        fn_exp   = r_exp + EXP_CALC_W'(fn_inc[MANT_W]);
        fn_exp_w = CmpW'(fn_exp);
        fn_ovf   = (fn_exp_w > ExpMax) || (fn_exp_w < ExpMin);
    end

    // working register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_float       <= (i_req_type == REQ_FLOAT);
            r_sg          <= ld_sg;
            r_qneg        <= ld_sg && (i_a_value[MANT_W-1] ^ i_b_value[MANT_W-1]);
            r_neg         <= i_a_negative ^ i_b_negative;
            r_spec        <= ld_spec;
            r_spec_status <= ld_spec_status;
            r_spec_zero   <= ld_spec_zero;
            r_exp         <= ld_exp;
            if (i_req_type == REQ_FLOAT) begin
                r_rem <= ld_alt ? {i_a_value, 1'b0} : {1'b0, i_a_value};
                r_q   <= '0;
                r_b   <= i_b_value;
            end else begin
                r_rem <= '0;
                r_q   <= ld_ma;
                r_b   <= ld_mb;
            end
        end else if (i_cmd.step) begin
            r_rem <= r_float ? {st_new[MANT_W-1:0], 1'b0} : st_new;
            r_q   <= {r_q[MANT_W-2:0], st_ge};
        end
        if (i_cmd.round) begin
            r_round <= (r_rem >= {1'b0, r_b});
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_spec) begin
                o_status     <= r_spec_status;
                o_q_value    <= '0;
                o_q_exponent <= '0;
                o_q_signed   <= 1'b0;
                o_q_negative <= r_spec_zero ? r_neg : 1'b0;
                o_q_zero     <= r_spec_zero;
            end else if (r_float) begin
                o_status     <= fn_ovf ? ST_OVF : ST_OK;
                o_q_value    <= fn_fq;
                o_q_exponent <= fn_exp[EXP_IN_W-1:0];
                o_q_signed   <= 1'b0;
                o_q_negative <= r_neg;
                o_q_zero     <= 1'b0;
            end else begin
                o_status     <= ST_OK;
                o_q_value    <= r_qneg ? (~r_q + 1'b1) : r_q;
                o_q_exponent <= '0;
                o_q_signed   <= r_sg;
                o_q_negative <= 1'b0;
                o_q_zero     <= 1'b0;
            end
        end
    end

    assign o_stat.special = r_spec;

endmodule

FILE: rtl/int_and_float_divider_chk.sv
`include "int_and_float_divider_assert.svh"

module int_and_float_divider_chk
    import ifdiv_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [1:0]                 o_status,
    input logic [MANT_W-1:0]          o_q_value,
    input logic                       o_q_zero
);

    // an accepted item keeps the block busy
    `IFD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")

    // a result is shown only as the block goes idle after working
    `IFD_ASSERT_IMP(a_done_idle, o_done, !busy && $past(busy), "strobe while busy")

    // divide by zero returns a cleared quotient
    `IFD_ASSERT_IMP(a_div0_clear, o_done && (o_status == ST_DIV0), o_q_value == '0,
        "nonzero quotient on divide by zero")

    // a zero quotient is a clean result
    `IFD_ASSERT_IMP(a_zero_ok, o_done && o_q_zero,
        (o_status == ST_OK) && (o_q_value == '0), "bad zero result")

endmodule

bind int_and_float_divider int_and_float_divider_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_status  (o_status),
    .o_q_value (o_q_value),
    .o_q_zero  (o_q_zero)
);
